[hw/rtl/rwd_pkg.sv]
// Package for the reaction wheel step block: register indexes, sequencer states,
// divider request and response types, constants and sat32. No dependencies.
`timescale 1ns / 1ps
package rwd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_INERTIA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VISCOUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AERO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 3'd7;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OFF = 2'd1;
    localparam logic [1:0] FAULT_POS = 2'd2;
    localparam logic [1:0] FAULT_NEG = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FRIC_A,
        ST_FRIC_B,
        ST_FRIC_C,
        ST_FRIC_D,
        ST_DRIVE,
        ST_PGAIN,
        ST_IDEAL_DIV,
        ST_IDEAL_WAIT,
        ST_IDEAL_FIN,
        ST_CLAMP,
        ST_QDIV,
        ST_QWAIT,
        ST_QMUL,
        ST_NET,
        ST_DW_MUL,
        ST_DW_DIV,
        ST_DW_WAIT,
        ST_SPD_CLAMP,
        ST_RX_DIV,
        ST_RX_WAIT,
        ST_RX_FIN,
        ST_MOM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    function automatic logic signed [65:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] r;
        if (v > 66'sd2147483647)
            r = 66'sd2147483647;
        else if (v < -66'sd2147483648)
            r = -66'sd2147483648;
        else
            r = v;
        return r;
    endfunction

endpackage

[hw/rtl/rwd_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, shared by all divisions.
// Depends on rwd_pkg.
`timescale 1ns / 1ps
module rwd_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  rwd_pkg::div_req_t req,
    output rwd_pkg::div_rsp_t rsp
);
    localparam int W = rwd_pkg::DIV_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (req.start)
        begin
            quo_next = req.num;
            rem_next = '0;
            den_next = req.den;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[W-1:0], quo_reg[W-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;
    assign rsp.rem = rem_reg[W-1:0];

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg)) else $error("divider done without busy");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start |=> busy_reg || done_reg)
        else $error("divider dropped busy without done");
endmodule

[hw/rtl/reaction_wheel_dynamics_step_top.sv]
// Top level of the reaction wheel step block: ports, config registers, sequencer
// and shared multiplier. Depends on rwd_pkg and rwd_div.
//
//  channel  dir  payload
//  s_axis   in   step_time, torque_command, speed_command, speed_mode, fault_code
//  m_axis   out  wheel_speed, wheel_momentum, body_reaction_torque
//  cfg      in   register index, write data
//
// Each divide runs 64 steps, and the capped scaled quotient needs two passes.
// The ideal loop, quantizing, the speed update and a clamped reaction can all run
// on one item. A zero step time goes straight to the momentum state.
// Reset clears the speed and the config registers.
// A stall on m_axis holds the block in its output state.
// The block accepts no item until the result has been taken on m_axis.
`timescale 1ns / 1ps
module reaction_wheel_dynamics_step_top
#(
    parameter int CfgIdxW = rwd_pkg::CFG_IDX_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // step_time[31:0], torque_command[63:32], speed_command[95:64], speed_mode[96]
    input  logic [103:0]       s_axis_tdata,
    // fault_code[1:0]
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // wheel_speed[31:0], wheel_momentum[63:32], body_reaction_torque[95:64]
    output logic [95:0]        m_axis_tdata,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [31:0]        cfg_data
);
    typedef logic signed [65:0] s66_t;

    rwd_pkg::state_t state_reg, state_next;
    rwd_pkg::div_req_t dreq;
    rwd_pkg::div_rsp_t drsp;

    logic [31:0] inertia_reg, visc_reg, aero_reg, gain_reg;
    logic [30:0] maxt_reg, maxs_reg, dry_reg, quant_reg;
    logic signed [31:0] speed_reg;

    logic [31:0] dt_reg;
    logic signed [31:0] tcmd_reg, scmd_reg;
    logic mode_reg;
    logic [1:0] fault_reg;

    s66_t fric_reg, drv_reg, net_reg, nxt_reg, err_reg;
    logic [63:0] acc_reg, tmp_reg;
    logic clamped_reg;
    logic [31:0] out_spd_reg, out_mom_reg, out_rx_reg;
    logic [63:0] q_reg;
    logic [63:0] md_q_reg;
    logic        md_phase_reg;

    // shared 32x32 multiplier, operands picked by the state
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    function automatic logic [63:0] mag(input s66_t v);
        s66_t a;
        a = (v < 0) ? -v : v;
        return a[63:0];
    endfunction

    function automatic s66_t sgn(input logic [63:0] m, input logic neg);
        s66_t a;
        a = s66_t'({2'b00, m});
        return neg ? -a : a;
    endfunction

    logic [63:0] spd_mag, err_mag, net_mag, nxt_mag, dv_mag;
    s66_t dv_val, rx_clamp_val, rx_net_val, mom_val;
    assign spd_mag = mag(s66_t'(speed_reg));
    assign err_mag = mag(err_reg);
    assign net_mag = mag(net_reg);
    assign nxt_mag = mag(nxt_reg);
    assign dv_val = nxt_reg - s66_t'(speed_reg);
    assign dv_mag = mag(dv_val);
    assign rx_clamp_val = rwd_pkg::sat32(-sgn(q_reg, dv_val < 0));
    assign rx_net_val = rwd_pkg::sat32(-net_reg);
    assign mom_val = rwd_pkg::sat32(sgn(mul_p >> 24, nxt_reg < 0));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            rwd_pkg::ST_FRIC_A: begin mul_a = visc_reg; mul_b = spd_mag[31:0]; end
            rwd_pkg::ST_FRIC_B: begin mul_a = spd_mag[31:0]; mul_b = spd_mag[31:0]; end
            rwd_pkg::ST_FRIC_C: begin mul_a = aero_reg; mul_b = tmp_reg[63:32]; end
            rwd_pkg::ST_FRIC_D: begin mul_a = aero_reg; mul_b = tmp_reg[31:0]; end
            rwd_pkg::ST_PGAIN: begin mul_a = gain_reg; mul_b = err_mag[31:0]; end
            rwd_pkg::ST_IDEAL_DIV, rwd_pkg::ST_RX_DIV:
            begin
                mul_a = inertia_reg;
                mul_b = (state_reg == rwd_pkg::ST_IDEAL_DIV) ? err_mag[31:0]
                        : dv_mag[31:0];
            end
            rwd_pkg::ST_QMUL: begin mul_a = q_reg[31:0]; mul_b = {1'b0, quant_reg}; end
            rwd_pkg::ST_DW_MUL: begin mul_a = net_mag[31:0]; mul_b = dt_reg; end
            rwd_pkg::ST_MOM: begin mul_a = inertia_reg; mul_b = nxt_mag[31:0]; end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rwd_pkg::ST_IDLE:
                if (s_axis_tvalid)
                    state_next = (s_axis_tdata[31:0] == '0) ? rwd_pkg::ST_MOM
                                                             : rwd_pkg::ST_FRIC_A;
            rwd_pkg::ST_FRIC_A: state_next = rwd_pkg::ST_FRIC_B;
            rwd_pkg::ST_FRIC_B: state_next = rwd_pkg::ST_FRIC_C;
            rwd_pkg::ST_FRIC_C: state_next = rwd_pkg::ST_FRIC_D;
            rwd_pkg::ST_FRIC_D: state_next = rwd_pkg::ST_DRIVE;
            rwd_pkg::ST_DRIVE:
                if (fault_reg == rwd_pkg::FAULT_NONE && mode_reg && inertia_reg != '0)
                    state_next = (gain_reg != '0) ? rwd_pkg::ST_PGAIN
                                                  : rwd_pkg::ST_IDEAL_DIV;
                else
                    state_next = rwd_pkg::ST_CLAMP;
            rwd_pkg::ST_PGAIN: state_next = rwd_pkg::ST_CLAMP;
            rwd_pkg::ST_IDEAL_DIV: state_next = rwd_pkg::ST_IDEAL_WAIT;
            rwd_pkg::ST_IDEAL_WAIT: if (drsp.done) state_next = rwd_pkg::ST_IDEAL_FIN;
            rwd_pkg::ST_IDEAL_FIN: state_next = rwd_pkg::ST_CLAMP;
            rwd_pkg::ST_CLAMP:
                state_next = (quant_reg != '0) ? rwd_pkg::ST_QDIV : rwd_pkg::ST_NET;
            rwd_pkg::ST_QDIV: state_next = rwd_pkg::ST_QWAIT;
            rwd_pkg::ST_QWAIT: if (drsp.done) state_next = rwd_pkg::ST_QMUL;
            rwd_pkg::ST_QMUL: state_next = rwd_pkg::ST_NET;
            rwd_pkg::ST_NET:
                state_next = (inertia_reg != '0) ? rwd_pkg::ST_DW_MUL
                                                 : rwd_pkg::ST_SPD_CLAMP;
            rwd_pkg::ST_DW_MUL: state_next = rwd_pkg::ST_DW_DIV;
            rwd_pkg::ST_DW_DIV: state_next = rwd_pkg::ST_DW_WAIT;
            rwd_pkg::ST_DW_WAIT: if (drsp.done) state_next = rwd_pkg::ST_SPD_CLAMP;
            rwd_pkg::ST_SPD_CLAMP: state_next = rwd_pkg::ST_RX_DIV;
            rwd_pkg::ST_RX_DIV:
                state_next = clamped_reg ? rwd_pkg::ST_RX_WAIT : rwd_pkg::ST_RX_FIN;
            rwd_pkg::ST_RX_WAIT: if (drsp.done) state_next = rwd_pkg::ST_RX_FIN;
            rwd_pkg::ST_RX_FIN: state_next = rwd_pkg::ST_MOM;
            rwd_pkg::ST_MOM: state_next = rwd_pkg::ST_OUT;
            rwd_pkg::ST_OUT: if (m_axis_tready) state_next = rwd_pkg::ST_IDLE;
            default: state_next = rwd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num = '0;
        dreq.den = 64'd1;
        unique case (state_reg)
            rwd_pkg::ST_IDEAL_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num = mul_p;
                dreq.den = {32'd0, dt_reg};
            end
            // The first pass of the scaled quotient hands its remainder on.
            rwd_pkg::ST_IDEAL_WAIT, rwd_pkg::ST_RX_WAIT:
            begin
                dreq.start = drsp.done && !md_phase_reg;
                dreq.num = {drsp.rem[55:0], 8'd0};
                dreq.den = {32'd0, dt_reg};
            end
            rwd_pkg::ST_QDIV:
            begin
                dreq.start = 1'b1;
                dreq.num = mag(drv_reg);
                dreq.den = {33'd0, quant_reg};
            end
            rwd_pkg::ST_DW_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num = acc_reg;
                dreq.den = {24'd0, inertia_reg, 8'd0};
            end
            rwd_pkg::ST_RX_DIV:
            begin
                dreq.start = clamped_reg;
                dreq.num = mul_p;
                dreq.den = {32'd0, dt_reg};
            end
            default: ;
        endcase
    end

    rwd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // second pass of mul_div: floor((rem<<8)/d) for d < 2^32 fits in one
    // compare chain only by division, so the divider is run on p<<8 split:
    // quotient q and remainder r give (q<<8) + ((r<<8)/d). Here r<<8 < 2^40
    // and d >= 1, so (r<<8)/d is done by a second short pass of the divider.
    logic [63:0] md_result;
    assign md_result = (md_q_reg >= 64'h200_0000) ? 64'h2_0000_0000
                       : ((md_q_reg << 8) + drsp.quo);

    logic [63:0] qn;
    assign qn = drsp.quo + ((({drsp.rem[62:0], 1'b0}) >= {33'd0, quant_reg}) ? 64'd1 : 64'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwd_pkg::ST_IDLE;
            speed_reg <= '0;
            inertia_reg <= '0;
            maxt_reg <= '0;
            maxs_reg <= '0;
            dry_reg <= '0;
            visc_reg <= '0;
            aero_reg <= '0;
            gain_reg <= '0;
            quant_reg <= '0;
            md_phase_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == rwd_pkg::ST_IDEAL_WAIT || state_reg == rwd_pkg::ST_RX_WAIT)
            begin
                if (drsp.done && !md_phase_reg)
                    md_phase_reg <= 1'b1;
                else if (drsp.done)
                    md_phase_reg <= 1'b0;
            end
            if (!((state_reg == rwd_pkg::ST_IDEAL_WAIT || state_reg == rwd_pkg::ST_RX_WAIT)
                  && drsp.done && !md_phase_reg))
                state_reg <= state_next;
            if (state_reg == rwd_pkg::ST_SPD_CLAMP)
                speed_reg <= speed_reg;
            if (state_reg == rwd_pkg::ST_RX_FIN)
                speed_reg <= nxt_reg[31:0];
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rwd_pkg::REG_INERTIA: inertia_reg <= cfg_data;
                    rwd_pkg::REG_MAX_TORQUE: maxt_reg <= cfg_data[30:0];
                    rwd_pkg::REG_MAX_SPEED: maxs_reg <= cfg_data[30:0];
                    rwd_pkg::REG_DRY: dry_reg <= cfg_data[30:0];
                    rwd_pkg::REG_VISCOUS: visc_reg <= cfg_data;
                    rwd_pkg::REG_AERO: aero_reg <= cfg_data;
                    rwd_pkg::REG_GAIN: gain_reg <= cfg_data;
                    rwd_pkg::REG_QUANTUM: quant_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rwd_pkg::ST_IDLE:
            begin
                dt_reg <= s_axis_tdata[31:0];
                tcmd_reg <= s_axis_tdata[63:32];
                scmd_reg <= s_axis_tdata[95:64];
                mode_reg <= s_axis_tdata[96];
                fault_reg <= s_axis_tuser;
                nxt_reg <= s66_t'(speed_reg);
                clamped_reg <= 1'b0;
                out_rx_reg <= '0;
            end
            rwd_pkg::ST_FRIC_A:
            begin
                acc_reg <= {33'd0, dry_reg} + (mul_p >> 24);
                err_reg <= s66_t'(scmd_reg) - s66_t'(speed_reg);
            end
            rwd_pkg::ST_FRIC_B: tmp_reg <= mul_p;
            rwd_pkg::ST_FRIC_C: q_reg <= mul_p;
            rwd_pkg::ST_FRIC_D:
            begin
                if ((acc_reg + ((q_reg + (mul_p >> 32)) >> 16)) > 64'h7FFF_FFFF)
                    fric_reg <= (speed_reg > 0) ? -66'sd2147483647
                              : (speed_reg < 0) ? 66'sd2147483647 : '0;
                else
                    fric_reg <= (speed_reg > 0)
                        ? -s66_t'({2'b0, acc_reg + ((q_reg + (mul_p >> 32)) >> 16)})
                        : (speed_reg < 0)
                        ? s66_t'({2'b0, acc_reg + ((q_reg + (mul_p >> 32)) >> 16)})
                        : '0;
            end
            rwd_pkg::ST_DRIVE:
            begin
                case (fault_reg)
                    rwd_pkg::FAULT_OFF: drv_reg <= '0;
                    rwd_pkg::FAULT_POS: drv_reg <= s66_t'({35'd0, maxt_reg});
                    rwd_pkg::FAULT_NEG: drv_reg <= -s66_t'({35'd0, maxt_reg});
                    default: drv_reg <= s66_t'(tcmd_reg);
                endcase
            end
            rwd_pkg::ST_PGAIN:
                drv_reg <= rwd_pkg::sat32(sgn(mul_p >> 24, err_reg < 0));
            rwd_pkg::ST_IDEAL_WAIT, rwd_pkg::ST_RX_WAIT:
                if (drsp.done && !md_phase_reg)
                    md_q_reg <= drsp.quo;
            rwd_pkg::ST_IDEAL_FIN:
                drv_reg <= rwd_pkg::sat32(sgn(q_reg, err_reg < 0) - fric_reg);
            rwd_pkg::ST_CLAMP:
                if (maxt_reg != '0)
                begin
                    if (drv_reg > s66_t'({35'd0, maxt_reg}))
                        drv_reg <= s66_t'({35'd0, maxt_reg});
                    else if (drv_reg < -s66_t'({35'd0, maxt_reg}))
                        drv_reg <= -s66_t'({35'd0, maxt_reg});
                end
            rwd_pkg::ST_QWAIT: if (drsp.done) q_reg <= qn;
            rwd_pkg::ST_QMUL:
                drv_reg <= rwd_pkg::sat32(sgn(q_reg[32] ? 64'hFFFF_FFFF_FF : mul_p,
                                               drv_reg < 0));
            rwd_pkg::ST_NET: net_reg <= drv_reg + fric_reg;
            rwd_pkg::ST_DW_MUL: acc_reg <= mul_p;
            rwd_pkg::ST_DW_WAIT:
                if (drsp.done)
                    nxt_reg <= s66_t'(speed_reg) + sgn(drsp.quo, net_reg < 0);
            rwd_pkg::ST_SPD_CLAMP:
            begin
                if (maxs_reg != '0)
                begin
                    if (nxt_reg > s66_t'({35'd0, maxs_reg}))
                    begin
                        nxt_reg <= s66_t'({35'd0, maxs_reg});
                        clamped_reg <= 1'b1;
                    end
                    else if (nxt_reg < -s66_t'({35'd0, maxs_reg}))
                    begin
                        nxt_reg <= -s66_t'({35'd0, maxs_reg});
                        clamped_reg <= 1'b1;
                    end
                end
                else if (rwd_pkg::sat32(nxt_reg) != nxt_reg)
                begin
                    nxt_reg <= rwd_pkg::sat32(nxt_reg);
                    clamped_reg <= 1'b1;
                end
            end
            rwd_pkg::ST_RX_FIN:
                if (clamped_reg)
                    out_rx_reg <= rx_clamp_val[31:0];
                else
                    out_rx_reg <= (inertia_reg != '0) ? rx_net_val[31:0] : 32'd0;
            rwd_pkg::ST_MOM:
            begin
                out_spd_reg <= nxt_reg[31:0];
                out_mom_reg <= mom_val[31:0];
            end
            default: ;
        endcase
        if ((state_reg == rwd_pkg::ST_IDEAL_WAIT || state_reg == rwd_pkg::ST_RX_WAIT)
            && drsp.done && md_phase_reg)
            q_reg <= md_result;
    end

    assign s_axis_tready = (state_reg == rwd_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == rwd_pkg::ST_OUT);
    assign m_axis_tdata = {out_rx_reg, out_mom_reg, out_spd_reg};

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> speed_reg == $signed(out_spd_reg))
        else $error("stored speed differs from result");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !drsp.busy) else $error("divider busy while idle");
endmodule
